### hdl/poluw_pkg.sv
`default_nettype none
package poluw_pkg;

  // Field widths
  localparam int unsigned ROW_W    = 12;
  localparam int unsigned COL_W    = 12;
  localparam int unsigned RAD_W    = 13;
  localparam int unsigned UW_W     = 13;
  localparam int unsigned CTR_W    = 12;
  localparam int unsigned SIZE_W   = 13;
  localparam int unsigned STRIDE_W = 15;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned COORD_W  = 15;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Sine table
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned QUARTER     = TABLE_DEPTH / 4;

  // Phase divider: dividend is column << IDX_W, padded to whole stages
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = (COL_W + IDX_W + DIV_STEPS - 1) / DIV_STEPS;
  localparam int unsigned DVD_W      = DIV_STAGES * DIV_STEPS;

  // Angle constants in Q30 radians
  localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] Q30_HALF    = 64'd536870912;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FIRST_RADIUS = 3'd0,
    CFG_UNWRAP_WIDTH = 3'd1,
    CFG_CENTER_X     = 3'd2,
    CFG_CENTER_Y     = 3'd3,
    CFG_IMAGE_WIDTH  = 3'd4,
    CFG_IMAGE_HEIGHT = 3'd5,
    CFG_LINE_STRIDE  = 3'd6,
    CFG_FRAME_BASE   = 3'd7
  } cfg_reg_e;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef trig_t sine_table_t [TABLE_DEPTH];

  // Q15 sine of a Q30 angle: fold to first quadrant, Taylor series to x^17
  function automatic trig_t q15_sine(logic [63:0] ang);
    logic        neg;
    logic [63:0] a;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] q;
    neg = 1'b0;
    a   = ang;
    if (a >= PI_Q30) begin
      neg = 1'b1;
      a   = a - PI_Q30;
    end
    if (a > HALF_PI_Q30) a = PI_Q30 - a;
    x2   = (a * a) >> 30;
    term = a;
    sum  = a;
    for (int n = 1; n <= 8; n++) begin
      term = (term * x2) >> 30;
      // Divide by (2n)(2n+1)
      case (n)
        1: term = term / 64'd6;
        2: term = term / 64'd20;
        3: term = term / 64'd42;
        4: term = term / 64'd72;
        5: term = term / 64'd110;
        6: term = term / 64'd156;
        7: term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if ((n % 2) == 1) sum = sum - term;
      else sum = sum + term;
    end
    q = (sum * 64'd32767 + Q30_HALF) >> 30;
    if (q > 64'd32767) q = 64'd32767;
    return neg ? -trig_t'(q[TRIG_W-1:0]) : trig_t'(q[TRIG_W-1:0]);
  endfunction

  function automatic sine_table_t build_sine_table();
    sine_table_t t;
    logic [63:0] ang;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      ang  = (TWO_PI_Q30 * 64'(k)) / TABLE_DEPTH;
      t[k] = q15_sine(ang);
    end
    return t;
  endfunction

  localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage
`default_nettype wire

### hdl/polar_unwarp_address_generator.sv
`default_nettype none
// Polar unwarp address generator. Takes one panoramic coordinate (row, column)
// per clock on start_i and returns the source pixel coordinates, an in-image
// flag and the byte address through its pipeline, with a one-cycle strobe on
// result_valid_o. The pipeline never stalls: busy_o stays low and a new beat
// is taken every cycle. There is no back pressure on the result side: the
// receiver must take each result in the cycle its strobe is high. The
// pipeline is an entry register, the phase divider (column * 1024 /
// unwrap_width, four quotient bits per stage over six stages), then table
// lookup, multiply, round, bounds and address stages. Configuration writes
// are always ready and must be made while no beat is in flight.
module polar_unwarp_address_generator (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start_i,
  output logic                                      busy_o,
  input  wire logic [poluw_pkg::ROW_W-1:0]          out_row_i,
  input  wire logic [poluw_pkg::COL_W-1:0]          out_column_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [poluw_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [31:0]                          cfg_data_i,
  output logic                                      result_valid_o,
  output logic signed [poluw_pkg::COORD_W-1:0]      src_x_o,
  output logic signed [poluw_pkg::COORD_W-1:0]      src_y_o,
  output logic                                      in_image_o,
  output logic [poluw_pkg::ADDR_W-1:0]              pixel_address_o
);

  localparam int unsigned NS = poluw_pkg::DIV_STAGES;
  localparam int unsigned UW = poluw_pkg::UW_W;
  localparam int unsigned PROD_W = poluw_pkg::RAD_W + 1 + poluw_pkg::TRIG_W;
  localparam int unsigned SUM_W  = 31;
  localparam int unsigned MUL_W  = (poluw_pkg::COORD_W - 1) + poluw_pkg::STRIDE_W;

  // Configuration registers
  logic [poluw_pkg::CTR_W-1:0]    first_radius_q;
  logic [UW-1:0]                  unwrap_width_q;
  logic [poluw_pkg::CTR_W-1:0]    center_x_q;
  logic [poluw_pkg::CTR_W-1:0]    center_y_q;
  logic [poluw_pkg::SIZE_W-1:0]   image_width_q;
  logic [poluw_pkg::SIZE_W-1:0]   image_height_q;
  logic [poluw_pkg::STRIDE_W-1:0] line_stride_q;
  logic [poluw_pkg::ADDR_W-1:0]   frame_base_q;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = 1'b0;

  // Write configuration beats
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_radius_q <= '0;
      unwrap_width_q <= UW'(1024);
      center_x_q     <= '0;
      center_y_q     <= '0;
      image_width_q  <= poluw_pkg::SIZE_W'(640);
      image_height_q <= poluw_pkg::SIZE_W'(480);
      line_stride_q  <= poluw_pkg::STRIDE_W'(640);
      frame_base_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (poluw_pkg::cfg_reg_e'(cfg_index_i))
        poluw_pkg::CFG_FIRST_RADIUS: first_radius_q <= cfg_data_i[poluw_pkg::CTR_W-1:0];
        poluw_pkg::CFG_UNWRAP_WIDTH: unwrap_width_q <= cfg_data_i[UW-1:0];
        poluw_pkg::CFG_CENTER_X:     center_x_q     <= cfg_data_i[poluw_pkg::CTR_W-1:0];
        poluw_pkg::CFG_CENTER_Y:     center_y_q     <= cfg_data_i[poluw_pkg::CTR_W-1:0];
        poluw_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[poluw_pkg::SIZE_W-1:0];
        poluw_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[poluw_pkg::SIZE_W-1:0];
        poluw_pkg::CFG_LINE_STRIDE:  line_stride_q  <= cfg_data_i[poluw_pkg::STRIDE_W-1:0];
        poluw_pkg::CFG_FRAME_BASE:   frame_base_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Divider pipeline registers, index 0 is the entry stage
  logic                            vld_q [NS+1];
  logic [UW-1:0]                   rem_q [NS+1];
  logic [poluw_pkg::DVD_W-1:0]     dvd_q [NS+1];
  logic [poluw_pkg::IDX_W-1:0]     quo_q [NS+1];
  logic [poluw_pkg::RAD_W-1:0]     rad_q [NS+1];
  logic [UW-1:0]                   rem_d [NS];
  logic [poluw_pkg::DVD_W-1:0]     dvd_d [NS];
  logic [poluw_pkg::IDX_W-1:0]     quo_d [NS];

  // Capture the beat: radius and shifted column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q[0] <= 1'b0;
    else vld_q[0] <= start_i && !busy_o;
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    quo_q[0] <= '0;
    dvd_q[0] <= poluw_pkg::DVD_W'({out_column_i, {poluw_pkg::IDX_W{1'b0}}});
    rad_q[0] <= poluw_pkg::RAD_W'(first_radius_q) + poluw_pkg::RAD_W'(out_row_i);
  end

  // Restoring division, four quotient bits per stage
  for (genvar g = 0; g < NS; g++) begin : g_div
    always_comb begin
      logic [UW:0]                 r;
      logic [UW-1:0]               rr;
      logic [poluw_pkg::DVD_W-1:0] dv;
      logic [poluw_pkg::IDX_W-1:0] qq;
      logic                        qb;
      rr = rem_q[g];
      dv = dvd_q[g];
      qq = quo_q[g];
      for (int i = 0; i < poluw_pkg::DIV_STEPS; i++) begin
        r  = {rr, dv[poluw_pkg::DVD_W-1]};
        dv = {dv[poluw_pkg::DVD_W-2:0], 1'b0};
        qb = 1'b0;
        if (r >= {1'b0, unwrap_width_q}) begin
          r  = r - {1'b0, unwrap_width_q};
          qb = 1'b1;
        end
        qq = {qq[poluw_pkg::IDX_W-2:0], qb};
        rr = r[UW-1:0];
      end
      rem_d[g] = rr;
      dvd_d[g] = dv;
      quo_d[g] = qq;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) vld_q[g+1] <= 1'b0;
      else vld_q[g+1] <= vld_q[g];
    end

    always_ff @(posedge clk_i) begin
      rem_q[g+1] <= rem_d[g];
      dvd_q[g+1] <= dvd_d[g];
      quo_q[g+1] <= quo_d[g];
      rad_q[g+1] <= rad_q[g];
    end
  end

  // Table lookup: cosine is sine a quarter turn ahead
  logic [poluw_pkg::IDX_W-1:0] idx;
  logic [poluw_pkg::IDX_W-1:0] idx_c;
  logic                        tab_vld_q;
  poluw_pkg::trig_t            sin_q;
  poluw_pkg::trig_t            cos_q;
  logic [poluw_pkg::RAD_W-1:0] tab_rad_q;

  assign idx   = (unwrap_width_q == '0) ? '0 : quo_q[NS];
  assign idx_c = idx + poluw_pkg::IDX_W'(poluw_pkg::QUARTER);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) tab_vld_q <= 1'b0;
    else tab_vld_q <= vld_q[NS];
  end

  always_ff @(posedge clk_i) begin
    sin_q     <= poluw_pkg::SINE_TABLE[idx];
    cos_q     <= poluw_pkg::SINE_TABLE[idx_c];
    tab_rad_q <= rad_q[NS];
  end

  // Multiply radius by sine and cosine
  logic                     mul_vld_q;
  logic signed [PROD_W-1:0] px_q;
  logic signed [PROD_W-1:0] py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) mul_vld_q <= 1'b0;
    else mul_vld_q <= tab_vld_q;
  end

  always_ff @(posedge clk_i) begin
    px_q <= $signed({1'b0, tab_rad_q}) * sin_q;
    py_q <= $signed({1'b0, tab_rad_q}) * cos_q;
  end

  // Add center and round half away from zero
  function automatic logic [poluw_pkg::COORD_W-1:0] round_q15(logic signed [SUM_W-1:0] v);
    logic [SUM_W-1:0] t;
    if (!v[SUM_W-1]) begin
      t = SUM_W'(v) + SUM_W'(16384);
      return t[29:15];
    end
    t = SUM_W'(-v) + SUM_W'(16384);
    return -t[29:15];
  endfunction

  logic signed [SUM_W-1:0]            vx;
  logic signed [SUM_W-1:0]            vy;
  logic                               rnd_vld_q;
  logic [poluw_pkg::COORD_W-1:0]      x_q;
  logic [poluw_pkg::COORD_W-1:0]      y_q;

  assign vx = $signed(SUM_W'({center_x_q, 15'b0})) + SUM_W'(px_q);
  assign vy = $signed(SUM_W'({center_y_q, 15'b0})) + SUM_W'(py_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) rnd_vld_q <= 1'b0;
    else rnd_vld_q <= mul_vld_q;
  end

  always_ff @(posedge clk_i) begin
    x_q <= round_q15(vx);
    y_q <= round_q15(vy);
  end

  // Bounds test and row offset
  logic                          bnd_vld_q;
  logic                          inside_q;
  logic [MUL_W-1:0]              row_off_q;
  logic [poluw_pkg::COORD_W-1:0] bx_q;
  logic [poluw_pkg::COORD_W-1:0] by_q;
  logic                          in_bounds;

  assign in_bounds = !x_q[poluw_pkg::COORD_W-1] && !y_q[poluw_pkg::COORD_W-1] &&
                     ({2'b0, x_q[poluw_pkg::COORD_W-2:0]} < {3'b0, image_width_q}) &&
                     ({2'b0, y_q[poluw_pkg::COORD_W-2:0]} < {3'b0, image_height_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bnd_vld_q <= 1'b0;
    else bnd_vld_q <= rnd_vld_q;
  end

  always_ff @(posedge clk_i) begin
    inside_q  <= in_bounds;
    row_off_q <= y_q[poluw_pkg::COORD_W-2:0] * line_stride_q;
    bx_q      <= x_q;
    by_q      <= y_q;
  end

  // Form the byte address and drive the result
  logic [poluw_pkg::ADDR_W-1:0] addr;

  assign addr = frame_base_q + poluw_pkg::ADDR_W'(row_off_q) +
                poluw_pkg::ADDR_W'(bx_q[poluw_pkg::COORD_W-2:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) result_valid_o <= 1'b0;
    else result_valid_o <= bnd_vld_q;
  end

  always_ff @(posedge clk_i) begin
    src_x_o         <= $signed(bx_q);
    src_y_o         <= $signed(by_q);
    in_image_o      <= inside_q;
    pixel_address_o <= inside_q ? addr : '0;
  end

endmodule
`default_nettype wire
